// ----- src/tps_pkg.sv -----
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants for the task priority selector
// Opcodes, sequencer states, port widths and the scan unit control word.
// ----------------------------------------------------------------------------
package tps_pkg;

   localparam int OPCODE_BITS      = 2;
   localparam int TASK_INDEX_BITS  = 8;
   localparam int OWNER_PORT_BITS  = 16;
   localparam int PRIO_PORT_BITS   = 30;

   localparam int TASK_SLOTS_DEFAULT = 256;
   localparam int PRIO_BITS_DEFAULT  = 30;
   localparam int OWNER_BITS_DEFAULT = 16;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_ADD    = 2'd0,
      OP_EDIT   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_EXEC   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_EDIT_RD,
      ST_EDIT_WR,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic init;     // drop the running best
      logic cmp_en;   // table word on the read port is live
   } scan_ctrl_type;

endpackage

// ----- src/task_priority_selector_top.sv -----
// ----------------------------------------------------------------------------
// task_priority_selector_top: indexed max-priority task table
// Add, edit, remove and execute-top on a table of tasks held in one RAM; the
// execute item scans every slot through a single compare unit.
//
//   channel  ports                                          handshake
//   -------  ---------------------------------------------  ------------------
//   request  req_opcode req_task_index req_owner req_prio   start & !busy
//   result   rsp_found rsp_owner_out                         rsp_valid strobe
//
// After reset a clearing pass writes every slot, busy high. Add and
// remove hold busy through the update state, edit through a read then a
// write state. Execute holds it through the scan state (one RAM read per
// slot), a drain state for the read pipe, and a result state that presents
// the result and clears the task. The one-cycle result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module task_priority_selector_top #(
   parameter int TASK_SLOTS = tps_pkg::TASK_SLOTS_DEFAULT,
   parameter int PRIO_BITS  = tps_pkg::PRIO_BITS_DEFAULT,
   parameter int OWNER_BITS = tps_pkg::OWNER_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [tps_pkg::OPCODE_BITS-1:0]     req_opcode,
   input  logic [tps_pkg::TASK_INDEX_BITS-1:0] req_task_index,
   input  logic [tps_pkg::OWNER_PORT_BITS-1:0] req_owner,
   input  logic [tps_pkg::PRIO_PORT_BITS-1:0]  req_prio,
   output logic                                rsp_valid,
   output logic                                rsp_found,
   output logic [tps_pkg::OWNER_PORT_BITS-1:0] rsp_owner_out
);

   localparam int SLOT_BITS = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int WORD_BITS = 1 + OWNER_BITS + PRIO_BITS;
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TASK_SLOTS - 1);

   tps_pkg::state_type    state_ff, state_in;
   tps_pkg::opcode_type   op_ff, op_in;
   logic [SLOT_BITS-1:0]  idx_ff, idx_in;
   logic                  in_range_ff, in_range_in;
   logic [OWNER_BITS-1:0] owner_ff, owner_in;
   logic [PRIO_BITS-1:0]  prio_ff, prio_in;
   logic [SLOT_BITS-1:0]  cnt_ff, cnt_in;
   logic [SLOT_BITS-1:0]  cmp_slot_ff;
   logic                  cmp_en_ff;

   logic                  accept;
   logic [31:0]           idx_wide;
   logic [31:0]           owner_wide;
   logic [31:0]           prio_wide;
   logic [31:0]           best_owner_wide;

   logic                  ram_we;
   logic [SLOT_BITS-1:0]  ram_waddr;
   logic [WORD_BITS-1:0]  ram_wdata;
   logic [SLOT_BITS-1:0]  ram_raddr;
   logic [WORD_BITS-1:0]  ram_rdata;

   logic                  rd_valid;
   logic [OWNER_BITS-1:0] rd_owner;
   logic [PRIO_BITS-1:0]  rd_prio;

   tps_pkg::scan_ctrl_type scan_ctrl;
   logic                   have;
   logic [SLOT_BITS-1:0]   best_slot;
   logic [OWNER_BITS-1:0]  best_owner;

   assign accept     = start && (state_ff == tps_pkg::ST_IDLE);
   assign idx_wide   = 32'(req_task_index);
   assign owner_wide = 32'(req_owner);
   assign prio_wide  = 32'(req_prio);

   assign {rd_valid, rd_owner, rd_prio} = ram_rdata;
   assign best_owner_wide = 32'(best_owner);

   // capture the item on accept
   always_comb begin
      op_in       = op_ff;
      idx_in      = idx_ff;
      in_range_in = in_range_ff;
      owner_in    = owner_ff;
      prio_in     = prio_ff;
      if (accept) begin
         op_in       = tps_pkg::opcode_type'(req_opcode);
         idx_in      = idx_wide[SLOT_BITS-1:0];
         in_range_in = (idx_wide < 32'(TASK_SLOTS));
         owner_in    = owner_wide[OWNER_BITS-1:0];
         prio_in     = prio_wide[PRIO_BITS-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tps_pkg::ST_CLEAR: begin
            if (cnt_ff == LAST_SLOT) begin
               state_in = tps_pkg::ST_IDLE;
            end
         end
         tps_pkg::ST_IDLE: begin
            if (start) begin
               case (tps_pkg::opcode_type'(req_opcode))
                  tps_pkg::OP_ADD:    state_in = tps_pkg::ST_UPDATE;
                  tps_pkg::OP_REMOVE: state_in = tps_pkg::ST_UPDATE;
                  tps_pkg::OP_EDIT:   state_in = tps_pkg::ST_EDIT_RD;
                  tps_pkg::OP_EXEC:   state_in = tps_pkg::ST_SCAN;
                  default:            state_in = tps_pkg::ST_IDLE;
               endcase
            end
         end
         tps_pkg::ST_UPDATE:  state_in = tps_pkg::ST_IDLE;
         tps_pkg::ST_EDIT_RD: state_in = tps_pkg::ST_EDIT_WR;
         tps_pkg::ST_EDIT_WR: state_in = tps_pkg::ST_IDLE;
         tps_pkg::ST_SCAN: begin
            if (cnt_ff == LAST_SLOT) begin
               state_in = tps_pkg::ST_DRAIN;
            end
         end
         tps_pkg::ST_DRAIN:  state_in = tps_pkg::ST_RESULT;
         tps_pkg::ST_RESULT: state_in = tps_pkg::ST_IDLE;
         default:            state_in = tps_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      busy           = 1'b1;
      cnt_in         = cnt_ff;
      ram_we         = 1'b0;
      ram_waddr      = idx_ff;
      ram_wdata      = {1'b1, owner_ff, prio_ff};
      ram_raddr      = idx_ff;
      scan_ctrl      = '0;
      rsp_valid      = 1'b0;
      rsp_found      = 1'b0;
      rsp_owner_out  = '0;
      case (state_ff)
         tps_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = '0;
            cnt_in    = cnt_ff + 1'b1;
         end
         tps_pkg::ST_IDLE: begin
            busy           = 1'b0;
            cnt_in         = '0;
            scan_ctrl.init = 1'b1;
         end
         tps_pkg::ST_UPDATE: begin
            case (op_ff)
               tps_pkg::OP_ADD: begin
                  ram_we = in_range_ff;
               end
               tps_pkg::OP_REMOVE: begin
                  ram_we    = in_range_ff;
                  ram_wdata = {1'b0, owner_ff, prio_ff};
               end
               default: begin
                  ram_we = 1'b0;
               end
            endcase
         end
         tps_pkg::ST_EDIT_RD: begin
            ram_raddr = idx_ff;
         end
         tps_pkg::ST_EDIT_WR: begin
            // only a present task takes the new priority
            ram_we    = in_range_ff && rd_valid;
            ram_wdata = {1'b1, rd_owner, prio_ff};
         end
         tps_pkg::ST_SCAN: begin
            ram_raddr        = cnt_ff;
            cnt_in           = cnt_ff + 1'b1;
            scan_ctrl.cmp_en = cmp_en_ff;
         end
         tps_pkg::ST_DRAIN: begin
            scan_ctrl.cmp_en = cmp_en_ff;
         end
         tps_pkg::ST_RESULT: begin
            ram_we        = have;
            ram_waddr     = best_slot;
            ram_wdata     = {1'b0, best_owner, prio_ff};
            rsp_valid     = 1'b1;
            rsp_found     = have;
            rsp_owner_out = have ? best_owner_wide[tps_pkg::OWNER_PORT_BITS-1:0] : '0;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tps_pkg::ST_CLEAR;
         cnt_ff    <= '0;
         cmp_en_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         // read data for the slot issued this cycle lands next cycle
         cmp_en_ff <= (state_ff == tps_pkg::ST_SCAN);
      end
      cmp_slot_ff <= cnt_ff;
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      in_range_ff <= in_range_in;
      owner_ff    <= owner_in;
      prio_ff     <= prio_in;
   end

   tps_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (TASK_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   tps_scan_unit #(
      .SLOT_BITS  (SLOT_BITS),
      .PRIO_BITS  (PRIO_BITS),
      .OWNER_BITS (OWNER_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (scan_ctrl),
      .entry_valid (rd_valid),
      .entry_prio  (rd_prio),
      .entry_owner (rd_owner),
      .entry_slot  (cmp_slot_ff),
      .have        (have),
      .best_slot   (best_slot),
      .best_owner  (best_owner)
   );

endmodule

// ----- src/tps_ram.sv -----
// ----------------------------------------------------------------------------
// tps_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/tps_scan_unit.sv -----
// ----------------------------------------------------------------------------
// tps_scan_unit: running maximum over the task table
// Compares one table word a cycle against the best so far; ties go to the
// later (higher) slot.
// ----------------------------------------------------------------------------
module tps_scan_unit #(
   parameter int SLOT_BITS  = 8,
   parameter int PRIO_BITS  = 30,
   parameter int OWNER_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tps_pkg::scan_ctrl_type ctrl,
   input  logic                   entry_valid,
   input  logic [PRIO_BITS-1:0]   entry_prio,
   input  logic [OWNER_BITS-1:0]  entry_owner,
   input  logic [SLOT_BITS-1:0]   entry_slot,
   output logic                   have,
   output logic [SLOT_BITS-1:0]   best_slot,
   output logic [OWNER_BITS-1:0]  best_owner
);

   logic                  have_ff,  have_in;
   logic [PRIO_BITS-1:0]  prio_ff,  prio_in;
   logic [SLOT_BITS-1:0]  slot_ff,  slot_in;
   logic [OWNER_BITS-1:0] owner_ff, owner_in;
   logic                  take;

   // >= lets the higher slot win a tie, as slots arrive in ascending order
   assign take = ctrl.cmp_en && entry_valid && (!have_ff || entry_prio >= prio_ff);

   always_comb begin
      have_in  = have_ff;
      prio_in  = prio_ff;
      slot_in  = slot_ff;
      owner_in = owner_ff;
      if (ctrl.init) begin
         have_in = 1'b0;
      end else if (take) begin
         have_in  = 1'b1;
         prio_in  = entry_prio;
         slot_in  = entry_slot;
         owner_in = entry_owner;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
      prio_ff  <= prio_in;
      slot_ff  <= slot_in;
      owner_ff <= owner_in;
   end

   assign have       = have_ff;
   assign best_slot  = slot_ff;
   assign best_owner = owner_ff;

endmodule
